### design/ppstep_pkg.sv
// ---------------------------------------------------------------------------
// ppstep_pkg
// shared types, opcodes and the monomial exponent and monomial count functions
// ---------------------------------------------------------------------------
package ppstep_pkg;

  localparam int unsigned Attrs  = 4;
  localparam int unsigned AttrW  = 13;
  localparam int unsigned CoefW  = 24;
  localparam int unsigned MonoW  = 17;
  localparam int unsigned ScoreW = 32;
  localparam int unsigned StepW  = 12;
  localparam int unsigned FracW  = 12;

  typedef enum logic [1:0] {
    OP_CLASSIFY = 2'd0,
    OP_TRAIN    = 2'd1,
    OP_RESET    = 2'd2,
    OP_NONE     = 2'd3
  } op_e;

  typedef enum logic [0:0] {
    REG_LEARN_STEP    = 1'b0,
    REG_INITIAL_COEFF = 1'b1
  } reg_e;

  typedef struct packed {
    logic [1:0]       op;
    logic [AttrW-1:0] attr_0;
    logic [AttrW-1:0] attr_1;
    logic [AttrW-1:0] attr_2;
    logic [AttrW-1:0] attr_3;
    logic             label_positive;
  } in_t;

  typedef struct packed {
    logic                     predicted_positive;
    logic                     mistake;
    logic signed [ScoreW-1:0] score;
  } out_t;

  // back-end state machine
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MONO,
    ST_PROD,
    ST_ACC,
    ST_UPD,
    ST_DONE
  } be_state_e;

  // exponent of attribute k in term t, lexicographic order, attribute 0 most significant
  function automatic logic [2:0] term_exp(input int t, input int k, input int attrs,
                                         input int order);
    int digit [8];
    int cnt;
    int sum;
    int j;
    logic [2:0] res;
    res = '0;
    cnt = 0;
    for (j = 0; j < 8; j++) digit[j] = 0;
    for (int n = 0; n < 65536; n++) begin
      sum = 0;
      for (j = 0; j < attrs; j++) sum += digit[j];
      if (sum <= order) begin
        if (cnt == t) res = 3'(digit[k]);
        cnt++;
      end
      j = attrs - 1;
      while (j >= 0 && digit[j] == order) begin
        digit[j] = 0;
        j--;
      end
      if (j < 0) break;
      digit[j]++;
    end
    return res;
  endfunction

  // number of monomials of total degree up to order, by the same odometer walk
  function automatic int mono_count(input int attrs, input int order);
    int digit [8];
    int c;
    int sum;
    int j;
    c = 0;
    for (j = 0; j < 8; j++) digit[j] = 0;
    for (int n = 0; n < 65536; n++) begin
      sum = 0;
      for (j = 0; j < attrs; j++) sum += digit[j];
      if (sum <= order) c++;
      j = attrs - 1;
      while (j >= 0 && digit[j] == order) begin
        digit[j] = 0;
        j--;
      end
      if (j < 0) break;
      digit[j]++;
    end
    return c;
  endfunction

endpackage

### design/ppstep_front.sv
// ---------------------------------------------------------------------------
// ppstep_front
// accepts items and queues them for the back end
// ---------------------------------------------------------------------------
module ppstep_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  ppstep_pkg::in_t   item_i,
  output logic              q_valid_o,
  input  logic              q_take_i,
  output ppstep_pkg::in_t   q_item_o
);
  import ppstep_pkg::*;

  // two-entry queue
  in_t        mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full      = cnt_q == 2'd2;
  assign do_push   = push && !full;
  assign q_valid_o = cnt_q != 2'd0;
  assign do_pop    = q_take_i && q_valid_o;
  assign q_item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= !wr_q;
      if (do_pop) rd_q <= !rd_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= item_i;
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count out of range");
  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0 || cnt_q == 2'd2) |-> wr_q == rd_q) else $error("pointer mismatch");
  a_full_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full && !do_pop |=> full) else $error("full dropped without pop");
`endif
endmodule

### design/ppstep_back.sv
// ---------------------------------------------------------------------------
// ppstep_back
// walks the terms with separate monomial and coefficient multipliers, then updates coefficients on a training mistake
// ---------------------------------------------------------------------------
module ppstep_back #(
  parameter int ORDER = 2,
  parameter int TERMS = 15
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  q_valid_i,
  output logic                                  q_take_o,
  input  ppstep_pkg::in_t                       q_item_i,
  input  logic [ppstep_pkg::StepW-1:0]          learn_step_i,
  input  logic signed [ppstep_pkg::CoefW-1:0]   initial_coeff_i,
  output logic                                  res_valid_o,
  input  logic                                  res_ready_i,
  output ppstep_pkg::out_t                      res_o
);
  import ppstep_pkg::*;

  localparam int Used = (TERMS < mono_count(Attrs, ORDER)) ? TERMS
                                                           : mono_count(Attrs, ORDER);
  localparam int TW   = (TERMS > 1) ? $clog2(TERMS) : 1;
  localparam int AW   = (Attrs > 1) ? $clog2(Attrs) : 1;
  localparam int PW   = $clog2(ORDER + 1) + 1;
  localparam int AccW = CoefW + MonoW + 8;

  be_state_e state_q, state_d;
  logic signed [CoefW-1:0] coef_q [TERMS];
  logic [TERMS-1:0]        nz_q;
  in_t                     item_q;
  logic [TW-1:0]           t_q;
  logic [AW-1:0]           k_q;
  logic [PW-1:0]           p_q;
  logic [MonoW-1:0]        mono_q;
  logic signed [AccW-1:0]  prod_q, acc_q;
  logic signed [CoefW-1:0] cur_coef;
  logic [AttrW-1:0]        cur_attr;
  logic [2:0]              cur_exp;
  logic [2:0]              exp_tab [TERMS][Attrs];
  logic [MonoW+AttrW-1:0]  mono_mul;
  logic signed [CoefW+MonoW:0] prod_mul;
  logic signed [ScoreW-1:0] score_sat;
  logic                    last_t, wrong, dir_up;
  logic signed [CoefW+1:0] upd;
  out_t                    res_q;
  logic                    res_v_q;

  // constant exponent table
  for (genvar gt = 0; gt < TERMS; gt++) begin : g_exp_t
    for (genvar gk = 0; gk < Attrs; gk++) begin : g_exp_k
      assign exp_tab[gt][gk] = term_exp(gt, gk, Attrs, ORDER);
    end
  end

  always_comb begin
    unique case (k_q)
      2'd0:    cur_attr = item_q.attr_0;
      2'd1:    cur_attr = item_q.attr_1;
      2'd2:    cur_attr = item_q.attr_2;
      default: cur_attr = item_q.attr_3;
    endcase
  end

  assign cur_exp  = exp_tab[t_q][k_q];
  assign cur_coef = coef_q[t_q];
  assign mono_mul = mono_q * cur_attr;
  assign prod_mul = cur_coef * $signed({1'b0, mono_q});
  assign last_t   = t_q == TW'(Used - 1);

  always_comb begin
    if (acc_q > AccW'(signed'(32'h7fffffff)))       score_sat = 32'sh7fffffff;
    else if (acc_q < -AccW'(signed'(33'sh80000000))) score_sat = 32'sh80000000;
    else score_sat = ScoreW'(acc_q);
  end

  assign wrong  = item_q.op == OP_TRAIN &&
                  ((score_sat > 0 && !item_q.label_positive) ||
                   (score_sat < 0 && item_q.label_positive));
  assign dir_up = item_q.label_positive;

  always_comb begin
    state_d  = state_q;
    q_take_o = 1'b0;
    unique case (state_q)
      ST_IDLE: if (q_valid_i && !res_v_q) begin
        q_take_o = 1'b1;
        state_d  = ST_MONO;
      end
      ST_MONO: begin
        if (item_q.op == OP_RESET || item_q.op == OP_NONE) state_d = ST_DONE;
        else if ((p_q >= PW'(cur_exp)) && k_q == AW'(Attrs - 1)) state_d = ST_PROD;
      end
      ST_PROD: state_d = ST_ACC;
      ST_ACC:  state_d = last_t ? ST_UPD : ST_MONO;
      ST_UPD:  state_d = last_t || !wrong ? ST_DONE : ST_UPD;
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      res_v_q <= 1'b0;
      for (int t = 0; t < TERMS; t++) coef_q[t] <= CoefW'(410);
    end else begin
      state_q <= state_d;
      if (res_v_q && res_ready_i) res_v_q <= 1'b0;
      if (state_q == ST_DONE) res_v_q <= 1'b1;
      if (state_q == ST_MONO && item_q.op == OP_RESET)
        for (int t = 0; t < TERMS; t++) coef_q[t] <= initial_coeff_i;
      if (state_q == ST_UPD && wrong && nz_q[t_q]) begin
        if (upd > 26'sd8388607)       coef_q[t_q] <= 24'sh7fffff;
        else if (upd < -26'sd8388608) coef_q[t_q] <= 24'sh800000;
        else                          coef_q[t_q] <= CoefW'(upd);
      end
    end
  end

  assign upd = dir_up ? cur_coef + $signed({2'b0, learn_step_i})
                      : cur_coef - $signed({2'b0, learn_step_i});

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        item_q <= q_item_i;
        t_q    <= '0;
        k_q    <= '0;
        p_q    <= '0;
        mono_q <= MonoW'(1 << FracW);
        acc_q  <= '0;
      end
      ST_MONO: begin
        if (p_q < PW'(cur_exp)) begin
          mono_q <= MonoW'(mono_mul >> FracW);
          p_q    <= p_q + 1'b1;
        end else if (k_q != AW'(Attrs - 1)) begin
          k_q <= k_q + 1'b1;
          p_q <= '0;
        end
      end
      ST_PROD: prod_q <= AccW'(prod_mul >>> FracW);
      ST_ACC: begin
        acc_q     <= acc_q + prod_q;
        nz_q[t_q] <= prod_q != 0;
        mono_q    <= MonoW'(1 << FracW);
        k_q       <= '0;
        p_q       <= '0;
        t_q       <= last_t ? '0 : t_q + 1'b1;
      end
      ST_UPD: begin
        t_q <= t_q + 1'b1;
        if (t_q == '0) begin
          res_q.predicted_positive <= score_sat >= 0;
          res_q.mistake            <= wrong;
          res_q.score              <= score_sat;
        end
      end
      ST_DONE: begin
        if (item_q.op == OP_RESET || item_q.op == OP_NONE) res_q <= '0;
      end
      default: ;
    endcase
  end

  assign res_valid_o = res_v_q;
  assign res_o       = res_q;

`ifndef ASSERT_OFF
  a_take_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_take_o |-> state_q == ST_IDLE && !res_v_q) else $error("take while busy");
  a_res_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_v_q) |-> $past(state_q) == ST_DONE) else $error("result without done");
  a_no_take_while_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_v_q |-> !q_take_o) else $error("overlap");
`endif
endmodule

### design/polynomial_perceptron_step.sv
// sequence: an item is queued and taken; for each term the monomial is built from the
// attributes, scaled by its coefficient and accumulated; then come update and done;
// a training mistake walks the update over all used terms; reset and unused ops skip it
// throughput: one item at a time, the back end takes the next once the result is popped
// reset: async active low; coefficients load 410, learn_step 41, initial_coeff 410
// ---------------------------------------------------------------------------
// polynomial_perceptron_step
// perceptron over polynomial features with a queue front end and serial back end
// ---------------------------------------------------------------------------
module polynomial_perceptron_step #(
  parameter int ORDER = 2,
  parameter int TERMS = 15
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  ppstep_pkg::in_t   item_i,
  output logic              empty,
  input  logic              pop,
  output ppstep_pkg::out_t  result_o,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [23:0]       cfg_data_i
);
  import ppstep_pkg::*;

  // configuration registers
  logic [StepW-1:0]        learn_step_q;
  logic signed [CoefW-1:0] initial_coeff_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      learn_step_q    <= StepW'(41);
      initial_coeff_q <= CoefW'(410);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_LEARN_STEP:    learn_step_q    <= cfg_data_i[StepW-1:0];
        REG_INITIAL_COEFF: initial_coeff_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // queue between front and back
  logic q_valid, q_take, res_valid;
  in_t  q_item;

  ppstep_front u_front (
    .clk_i, .rst_ni, .push, .full, .item_i,
    .q_valid_o(q_valid), .q_take_i(q_take), .q_item_o(q_item)
  );

  // serial term walker
  ppstep_back #(.ORDER(ORDER), .TERMS(TERMS)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_take_o(q_take), .q_item_i(q_item),
    .learn_step_i(learn_step_q), .initial_coeff_i(initial_coeff_q),
    .res_valid_o(res_valid), .res_ready_i(pop), .res_o(result_o)
  );

  assign empty = !res_valid;

`ifndef ASSERT_OFF
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty) else $error("result lost");
  a_result_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> $stable(result_o)) else $error("result changed");
  a_pop_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && pop |=> empty) else $error("result repeated");
`endif
endmodule
